// ----- design/pvl_pkg.sv -----
// ----------------------------------------------------------------------------
// pvl_pkg: shared types and constants of the positional value list
// Holds the list geometry, field widths, operation and status codes, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pvl_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	localparam int MODE_W     = 3;
	localparam int POS_W      = 6;
	localparam int VAL_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int FOUND_W    = 4;
	localparam int ENTRY_W    = 5;

	localparam int S_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((FOUND_W + VAL_W + ENTRY_W + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT   = 3'd0,
		MODE_DELETE   = 3'd1,
		MODE_SEARCH   = 3'd2,
		MODE_UPDATE   = 3'd3,
		MODE_TRAVERSE = 3'd4,
		MODE_COUNT    = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK       = 3'd0,
		STS_HIGH     = 3'd1,
		STS_EMPTY    = 3'd2,
		STS_NOTFOUND = 3'd3,
		STS_FULL     = 3'd4,
		STS_BADPOS   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_DECODE,
		CS_INS_SHIFT,
		CS_INS_PUT,
		CS_DEL_SHIFT,
		CS_SEARCH,
		CS_TRV_READ,
		CS_TRV_EMIT,
		CS_RESP
	} ctrl_state_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_COUNT,
		CUR_TARGET,
		CUR_ZERO,
		CUR_INC,
		CUR_DEC
	} cur_op_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_CUR,
		RD_CMP,
		RD_DOWN,
		RD_UP
	} rd_mode_t;

	typedef enum logic [1:0] {
		PSEL_ZERO,
		PSEL_IDX,
		PSEL_CUR
	} pos_sel_t;

	typedef struct packed {
		logic     take;
		cur_op_t  cur_op;
		rd_mode_t rd;
		logic     wr_val;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     emit;
		status_t  em_status;
		pos_sel_t em_pos;
		logic     em_data;
		logic     em_last;
	} pvl_cmd_t;

	typedef struct packed {
		mode_t   mode;
		status_t err;
		logic    cur_gt_tgt;
		logic    cur_next_lt_n;
		logic    cur_lt_n;
		logic    match;
		logic    cmp_pend;
		logic    is_last;
		logic    out_free;
	} pvl_stat_t;

endpackage

// ----- design/pvl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pvl_ctrl: operation sequencer of the positional value list
// Decodes each request, steps the datapath through shifts and scans one entry
// per cycle and through traversals entry by entry, and issues the result beats.
// ----------------------------------------------------------------------------
module pvl_ctrl
	import pvl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  pvl_stat_t stat,
	output pvl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	status_t     resp_status_q, resp_status_d;
	logic        resp_found_q, resp_found_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= CS_IDLE;
			resp_status_q <= STS_OK;
			resp_found_q  <= 1'b0;
		end else begin
			state_q       <= state_d;
			resp_status_q <= resp_status_d;
			resp_found_q  <= resp_found_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		resp_status_d = resp_status_q;
		resp_found_d  = resp_found_q;
		req_ready     = 1'b0;
		cmd           = '0;
		cmd.cur_op    = CUR_HOLD;
		cmd.rd        = RD_NONE;
		cmd.em_status = STS_OK;
		cmd.em_pos    = PSEL_ZERO;

		case (state_q)
			CS_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = CS_DECODE;
				end
			end
			CS_DECODE: begin
				resp_found_d  = 1'b0;
				resp_status_d = STS_OK;
				if (!(stat.mode inside {MODE_INSERT, MODE_DELETE, MODE_SEARCH,
					MODE_UPDATE, MODE_TRAVERSE, MODE_COUNT})) begin
					state_d = CS_IDLE;
				end else if (stat.err != STS_OK) begin
					resp_status_d = stat.err;
					state_d       = CS_RESP;
				end else begin
					case (stat.mode)
						MODE_INSERT: begin
							cmd.cur_op = CUR_COUNT;
							state_d    = CS_INS_SHIFT;
						end
						MODE_DELETE: begin
							cmd.cur_op = CUR_TARGET;
							state_d    = CS_DEL_SHIFT;
						end
						MODE_UPDATE: begin
							cmd.wr_val = 1'b1;
							state_d    = CS_RESP;
						end
						MODE_SEARCH: begin
							cmd.cur_op = CUR_ZERO;
							state_d    = CS_SEARCH;
						end
						MODE_TRAVERSE: begin
							cmd.cur_op = CUR_ZERO;
							state_d    = CS_TRV_READ;
						end
						default: begin
							state_d = CS_RESP;
						end
					endcase
				end
			end
			CS_INS_SHIFT: begin
				if (stat.cur_gt_tgt) begin
					cmd.rd     = RD_DOWN;
					cmd.cur_op = CUR_DEC;
				end else begin
					state_d = CS_INS_PUT;
				end
			end
			CS_INS_PUT: begin
				cmd.wr_val  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = CS_RESP;
			end
			CS_DEL_SHIFT: begin
				if (stat.cur_next_lt_n) begin
					cmd.rd     = RD_UP;
					cmd.cur_op = CUR_INC;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = CS_RESP;
				end
			end
			CS_SEARCH: begin
				if (stat.match) begin
					resp_found_d = 1'b1;
					state_d      = CS_RESP;
				end else if (stat.cur_lt_n) begin
					cmd.rd     = RD_CMP;
					cmd.cur_op = CUR_INC;
				end else if (!stat.cmp_pend) begin
					resp_status_d = STS_NOTFOUND;
					state_d       = CS_RESP;
				end
			end
			CS_TRV_READ: begin
				cmd.rd  = RD_CUR;
				state_d = CS_TRV_EMIT;
			end
			CS_TRV_EMIT: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.em_status = STS_OK;
					cmd.em_pos    = PSEL_CUR;
					cmd.em_data   = 1'b1;
					cmd.em_last   = stat.is_last;
					if (stat.is_last) begin
						state_d = CS_IDLE;
					end else begin
						cmd.cur_op = CUR_INC;
						state_d    = CS_TRV_READ;
					end
				end
			end
			CS_RESP: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.em_status = resp_status_q;
					cmd.em_pos    = resp_found_q ? PSEL_IDX : PSEL_ZERO;
					cmd.em_last   = 1'b1;
					state_d       = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

endmodule

// ----- design/pvl_datapath.sv -----
// ----------------------------------------------------------------------------
// pvl_datapath: storage and result path of the positional value list
// Holds the request, the element count, the cursor, the value memory with its
// registered read port, the error decode and the output beat register.
// ----------------------------------------------------------------------------
module pvl_datapath
	import pvl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  pvl_cmd_t             cmd,
	output pvl_stat_t            stat,
	input  logic [MODE_W-1:0]    req_mode,
	input  logic [POS_W-1:0]     req_pos,
	input  logic [VAL_W-1:0]     req_val,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  out_status,
	output logic [FOUND_W-1:0]   out_found,
	output logic [VAL_W-1:0]     out_data,
	output logic [ENTRY_W-1:0]   out_count,
	output logic                 out_last
);

	logic [VAL_W-1:0] mem [LIST_DEPTH];

	mode_t            mode_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cur_q;

	logic [VAL_W-1:0] rdata_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] wa_s1;
	logic             wr_pend_s1;
	logic             cmp_s1;

	logic             valid_q;
	status_t          status_q;
	logic [FOUND_W-1:0] found_q;
	logic [VAL_W-1:0] data_q;
	logic [ENTRY_W-1:0] ecount_q;
	logic             last_q;

	logic             pos_is_end, pos_bad, pos_neg;
	int               pos_mag, n_int;
	logic [CNT_W-1:0] target;
	status_t          err;
	logic             re, we;
	logic [IDX_W-1:0] ra, wa;
	logic [VAL_W-1:0] wd;
	logic [CNT_W:0]   cur_next;
	logic             out_free;

	assign pos_neg    = pos_q[POS_W-1];
	assign pos_is_end = (pos_q == {POS_W{1'b1}});
	assign pos_bad    = pos_neg && !pos_is_end;
	assign pos_mag    = int'(pos_q[POS_W-2:0]);
	assign n_int      = int'(count_q);

	always_comb begin
		if (pos_is_end) begin
			target = (mode_q == MODE_INSERT) ? count_q : count_q - 1'b1;
		end else begin
			target = CNT_W'(pos_q[POS_W-2:0]);
		end
	end

	always_comb begin
		err = STS_OK;
		case (mode_q)
			MODE_INSERT: begin
				if (pos_bad) begin
					err = STS_BADPOS;
				end else if (!pos_neg && pos_mag > n_int) begin
					err = STS_HIGH;
				end else if (n_int >= LIST_DEPTH) begin
					err = STS_FULL;
				end
			end
			MODE_DELETE, MODE_UPDATE: begin
				if (pos_bad) begin
					err = STS_BADPOS;
				end else if (!pos_neg && pos_mag >= n_int) begin
					err = STS_HIGH;
				end else if (count_q == '0) begin
					err = STS_EMPTY;
				end
			end
			MODE_SEARCH, MODE_TRAVERSE: begin
				if (count_q == '0) begin
					err = STS_EMPTY;
				end
			end
			default: begin
				err = STS_OK;
			end
		endcase
	end

	assign cur_next = {1'b0, cur_q} + 1'b1;
	assign out_free = !valid_q || out_ready;

	always_comb begin
		stat               = '0;
		stat.mode          = mode_q;
		stat.err           = err;
		stat.cur_gt_tgt    = (cur_q > target);
		stat.cur_next_lt_n = (cur_next < {1'b0, count_q});
		stat.cur_lt_n      = (cur_q < count_q);
		stat.match         = cmp_s1 && (rdata_s1 == val_q);
		stat.cmp_pend      = cmp_s1;
		stat.is_last       = (cur_next == {1'b0, count_q});
		stat.out_free      = out_free;
	end

	always_comb begin
		re = 1'b1;
		ra = cur_q[IDX_W-1:0];
		case (cmd.rd)
			RD_CUR, RD_CMP: begin
				ra = cur_q[IDX_W-1:0];
			end
			RD_DOWN: begin
				ra = IDX_W'(cur_q - 1'b1);
			end
			RD_UP: begin
				ra = cur_next[IDX_W-1:0];
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (cmd.wr_val) begin
			we = 1'b1;
			wa = target[IDX_W-1:0];
			wd = val_q;
		end else begin
			we = wr_pend_s1;
			wa = wa_s1;
			wd = rdata_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_s1 <= mem[ra];
			idx_s1   <= cur_q[IDX_W-1:0];
		end
		if (cmd.rd == RD_DOWN || cmd.rd == RD_UP) begin
			wa_s1 <= cur_q[IDX_W-1:0];
		end
		if (cmd.take) begin
			mode_q <= mode_t'(req_mode);
			pos_q  <= req_pos;
			val_q  <= req_val;
		end
		if (cmd.emit) begin
			status_q <= cmd.em_status;
			case (cmd.em_pos)
				PSEL_IDX: found_q <= FOUND_W'(idx_s1);
				PSEL_CUR: found_q <= FOUND_W'(cur_q);
				default:  found_q <= '0;
			endcase
			data_q   <= cmd.em_data ? rdata_s1 : '0;
			ecount_q <= ENTRY_W'(count_q);
			last_q   <= cmd.em_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cur_q      <= '0;
			wr_pend_s1 <= 1'b0;
			cmp_s1     <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			wr_pend_s1 <= (cmd.rd == RD_DOWN || cmd.rd == RD_UP);
			cmp_s1     <= (cmd.rd == RD_CMP);
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
			case (cmd.cur_op)
				CUR_COUNT:  cur_q <= count_q;
				CUR_TARGET: cur_q <= target;
				CUR_ZERO:   cur_q <= '0;
				CUR_INC:    cur_q <= cur_q + 1'b1;
				CUR_DEC:    cur_q <= cur_q - 1'b1;
				default:    cur_q <= cur_q;
			endcase
			if (cmd.emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_status = status_q;
	assign out_found  = found_q;
	assign out_data   = data_q;
	assign out_count  = ecount_q;
	assign out_last   = last_q;

endmodule

// ----- design/positional_value_list.sv -----
// ----------------------------------------------------------------------------
// positional_value_list: ordered list of values in a bounded store
// Inserts, deletes, updates, searches, traverses and counts an ordered list
// of up to LIST_DEPTH values held in a single-port-write memory.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser: mode; tdata: position, value
//   m_axis    out        tuser: status; tdata: found_position, data_value,
//                        entry_count; tlast: last
//
// One request is in work at a time; during shifts and scans the memory
// read port moves one entry per cycle. A beat is loaded only once the
// output register is free. After the last beat the sequencer returns to
// idle, where it accepts the next request.
// A result beat waits in the output register while the next step runs.
// After reset the list is empty; memory contents need no clearing.
// ----------------------------------------------------------------------------
module positional_value_list
	import pvl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [MODE_W-1:0]     s_axis_tuser,   // [2:0] mode
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [5:0] position, [37:6] value
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [STATUS_W-1:0]   m_axis_tuser,   // [2:0] status
	output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [3:0] found_position,
	                                              // [35:4] data_value,
	                                              // [40:36] entry_count
	output logic                  m_axis_tlast
);

	pvl_cmd_t              cmd;
	pvl_stat_t             stat;
	logic [FOUND_W-1:0]    out_found;
	logic [VAL_W-1:0]      out_data;
	logic [ENTRY_W-1:0]    out_count;

	pvl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pvl_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_mode   (s_axis_tuser),
		.req_pos    (s_axis_tdata[POS_W-1:0]),
		.req_val    (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_found  (out_found),
		.out_data   (out_data),
		.out_count  (out_count),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {{(M_TDATA_W-FOUND_W-VAL_W-ENTRY_W){1'b0}},
		out_count, out_data, out_found};

endmodule
